[src/pfr_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the framed receiver.
`timescale 1ns / 1ps

package pfr_pkg;

   localparam int MAX_FRAME_DEFAULT = 64;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] START_MARKER_RESET = 8'd170;
   localparam logic [7:0] END_MARKER_RESET   = 8'd85;

   // configuration port: two 32-bit registers at byte addresses 0 and 4
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_START = 1'b0;
   localparam logic CSR_IDX_END   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_END  = 3'd1,
      ST_COMPL   = 3'd2,
      ST_CRC     = 3'd3,
      ST_LONG    = 3'd4
   } frame_status_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
   } pfr_cfg_type;

   typedef struct packed {
      frame_status_type frame_status;
      logic [7:0]       seq_number;
      logic [7:0]       command_code;
      logic [7:0]       payload_length;
      logic [7:0]       first_payload;
   } pfr_result_type;

   // Modbus CRC-16, reflected, one byte LSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[src/pfr_if.sv]
// Request and response channel interfaces of the framed receiver.
`timescale 1ns / 1ps

interface pfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_data;

   modport source (output valid, output rx_data, input ready);
   modport sink   (input valid, input rx_data, output ready);
endinterface

interface pfr_rsp_if;
   import pfr_pkg::*;
   logic             valid;
   logic             ready;
   frame_status_type frame_status;
   logic [7:0]       seq_number;
   logic [7:0]       command_code;
   logic [7:0]       payload_length;
   logic [7:0]       first_payload;

   modport source (output valid, output frame_status, output seq_number,
                   output command_code, output payload_length, output first_payload,
                   input ready);
   modport sink   (input valid, input frame_status, input seq_number,
                   input command_code, input payload_length, input first_payload,
                   output ready);
endinterface

[src/pfr_csr.sv]
// APB-style register file holding the start and end marker bytes.
`timescale 1ns / 1ps

module pfr_csr
   import pfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output pfr_cfg_type           cfg
);

   logic [7:0] start_marker_ff, start_marker_in;
   logic [7:0] end_marker_ff, end_marker_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      prdata          = '0;
      unique case (paddr[2])
         CSR_IDX_START: begin
            prdata = {{(CSR_DATA_W-8){1'b0}}, start_marker_ff};
            if (wr_en) start_marker_in = pwdata[7:0];
         end
         CSR_IDX_END: begin
            prdata = {{(CSR_DATA_W-8){1'b0}}, end_marker_ff};
            if (wr_en) end_marker_in = pwdata[7:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
      end
   end

   assign cfg.start_marker = start_marker_ff;
   assign cfg.end_marker   = end_marker_ff;

endmodule

[src/pfr_core.sv]
// Frame tracker: byte position, held header fields and running CRC.
`timescale 1ns / 1ps

module pfr_core
   import pfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  pfr_cfg_type    cfg,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output logic           emit,
   output pfr_result_type result
);

   localparam int POS_W = $clog2(MAX_FRAME + 1);
   localparam int CW    = (POS_W > 9) ? POS_W + 1 : 10;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic             compl_ff, compl_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;

   logic [CW-1:0]    idx, len_w;
   logic [15:0]      crc_next;
   frame_status_type status;

   assign idx      = CW'(pos_ff);
   assign len_w    = CW'(len_ff);
   assign crc_next = crc16_byte(crc_ff, rx_byte);

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      seq_in    = seq_ff;
      cmd_in    = cmd_ff;
      compl_in  = compl_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      crc_lo_in = crc_lo_ff;
      emit      = 1'b0;
      status    = ST_OK;
      if (step) begin
         if (rx_byte == cfg.start_marker) begin
            // a start byte always reopens the frame
            pos_in    = POS_W'(1);
            crc_in    = CRC_INIT;
            seq_in    = '0;
            cmd_in    = '0;
            compl_in  = 1'b0;
            len_in    = '0;
            first_in  = '0;
            crc_lo_in = '0;
         end else if (pos_ff == '0) begin
            // idle byte: drop
         end else if (pos_ff >= POS_W'(MAX_FRAME)) begin
            emit   = 1'b1;
            status = ST_LONG;
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (idx <= CW'(4)) begin
               case (pos_ff[2:0])
                  3'd1:    seq_in   = rx_byte;
                  3'd2:    cmd_in   = rx_byte;
                  3'd3:    compl_in = (rx_byte == ~cmd_ff);
                  default: len_in   = rx_byte;
               endcase
               crc_in = crc_next;
            end else if (idx <= len_w + CW'(4)) begin
               if (idx == CW'(5)) first_in = rx_byte;
               crc_in = crc_next;
            end else if (idx == len_w + CW'(5)) begin
               crc_lo_in = rx_byte;
            end else if (idx == len_w + CW'(6)) begin
               crc_in = crc_ff ^ {rx_byte, crc_lo_ff};
            end else begin
               emit   = 1'b1;
               pos_in = '0;
               if (rx_byte != cfg.end_marker) status = ST_NO_END;
               else if (!compl_ff)             status = ST_COMPL;
               else if (crc_ff != '0)          status = ST_CRC;
               else                            status = ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= CRC_INIT;
         seq_ff    <= '0;
         cmd_ff    <= '0;
         compl_ff  <= 1'b0;
         len_ff    <= '0;
         first_ff  <= '0;
         crc_lo_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         seq_ff    <= seq_in;
         cmd_ff    <= cmd_in;
         compl_ff  <= compl_in;
         len_ff    <= len_in;
         first_ff  <= first_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   assign result.frame_status   = status;
   assign result.seq_number     = seq_ff;
   assign result.command_code   = cmd_ff;
   assign result.payload_length = len_ff;
   assign result.first_payload  = (len_ff != '0) ? first_ff : 8'h00;

endmodule

[src/pilot_framed_receiver_crc16_unit.sv]
// Top level of the framed receiver: input register, frame tracker, result register.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        rx_data
//   rsp_chan  out        valid/ready        frame_status, seq_number, command_code,
//                                           payload_length, first_payload
//   csr       in         APB psel/penable   start_marker, end_marker
//
// One byte per cycle sustained unless rsp_chan stalls; a byte's report passes the
// input register, then the result register fed by the combinational CRC and
// position logic. Reset is synchronous and needs no clearing pass.
// A stalled result register holds the input register, which then holds req_chan.
`timescale 1ns / 1ps

module pilot_framed_receiver_crc16_unit
   import pfr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   pfr_req_if.sink               req_chan,
   pfr_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   pfr_cfg_type    cfg;
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_data_ff, in_data_in;
   logic           out_valid_ff, out_valid_in;
   pfr_result_type out_data_ff, out_data_in;
   logic           advance, take, emit;
   pfr_result_type result;

   pfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pfr_core #(.MAX_FRAME(MAX_FRAME)) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .rx_byte (in_data_ff),
      .emit    (emit),
      .result  (result)
   );

   // advance the held request whenever the result register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_chan.rx_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = emit;
         if (emit) out_data_in = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.frame_status   = out_data_ff.frame_status;
   assign rsp_chan.seq_number     = out_data_ff.seq_number;
   assign rsp_chan.command_code   = out_data_ff.command_code;
   assign rsp_chan.payload_length = out_data_ff.payload_length;
   assign rsp_chan.first_payload  = out_data_ff.first_payload;

endmodule
